### hw/rtl/bfsa_pkg.sv
// Shared constants, codes and types of the best-fit segment allocator.
// Used through scoped names by every other RTL file except bfsa_ram.
`default_nettype none

package bfsa_pkg;

   localparam int SEGMENTS     = 16;
   localparam int GRANULE_LOG2 = 3;
   localparam int GRANULE      = 1 << GRANULE_LOG2;
   localparam int DATA_W       = 32;
   localparam int ENTRY_W      = 2 * DATA_W;
   localparam int IDX_W        = $clog2(SEGMENTS);
   localparam int PTR_W        = $clog2(SEGMENTS + 1);

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_NOFIT = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_ALLOC = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             check;
      logic             entry_valid;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic              exact;
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] len;
   } scan_res_type;

endpackage

`default_nettype wire

### hw/rtl/bfsa_req_if.sv
// Request channel of the allocator: valid/ready handshake and item payload.
// Depends on bfsa_pkg for field widths.
`default_nettype none

interface bfsa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [bfsa_pkg::DATA_W-1:0]   seg_start;
   logic [bfsa_pkg::DATA_W-1:0]   byte_count;

   modport source (output valid, kind, seg_start, byte_count, input ready);
   modport sink   (input valid, kind, seg_start, byte_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/bfsa_rsp_if.sv
// Response channel of the allocator: valid/ready handshake and result payload.
// Depends on bfsa_pkg for field widths.
`default_nettype none

interface bfsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [bfsa_pkg::DATA_W-1:0]   block_address;
   logic [bfsa_pkg::DATA_W-1:0]   free_total;

   modport source (output valid, status, block_address, free_total, input ready);
   modport sink   (input valid, status, block_address, free_total, output ready);
endinterface

`default_nettype wire

### hw/rtl/best_fit_segment_allocator.sv
// Best-fit segment allocator top level: control sequencer, valid bits, free
// total, response register. Depends on bfsa_pkg, bfsa_req_if, bfsa_rsp_if,
// bfsa_ram and bfsa_scan.
//
// Usage:
//   req_chan carries one transaction per item: kind 0 loads a free segment
//   (seg_start, byte_count) into the first empty table entry; kind 1
//   allocates byte_count bytes, rounded up to the granule, from the best-fit
//   segment. rsp_chan returns exactly one transaction per item: status,
//   block_address (zero unless status is ok) and the free total afterwards.
//   A load or a rejected request passes from acceptance through the finish
//   state to the response register; an allocation first runs through the
//   scan state, which reads one table entry per cycle from the segment RAM.
//   One item is in work at a time; req_chan.ready is high whenever the
//   sequencer is idle, even while a response waits in the output register.
//   Reset (synchronous, active high) empties the table and clears the free
//   total; segment RAM contents are not cleared and need no clearing pass.
//   When rsp_chan.ready is low the finished item holds in the sequencer
//   until the output register frees up.
`default_nettype none

module best_fit_segment_allocator (
   input  wire logic   clock,
   input  wire logic   reset,
   bfsa_req_if.sink    req_chan,
   bfsa_rsp_if.source  rsp_chan
);

   bfsa_pkg::state_type              state_ff, state_in;
   logic                             kind_ff, kind_in;
   logic [bfsa_pkg::DATA_W-1:0]      start_ff, start_in;
   logic [bfsa_pkg::DATA_W-1:0]      size_ff, size_in;
   bfsa_pkg::status_type             err_ff, err_in;
   logic [bfsa_pkg::PTR_W-1:0]       ptr_ff, ptr_in;
   logic                             chk_vld_ff, chk_vld_in;
   logic [bfsa_pkg::IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [bfsa_pkg::SEGMENTS-1:0]    valid_ff, valid_in;
   logic [bfsa_pkg::DATA_W-1:0]      free_ff, free_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bfsa_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [bfsa_pkg::DATA_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [bfsa_pkg::DATA_W-1:0]      rsp_total_ff, rsp_total_in;

   logic                             accept;
   logic                             slot_free;
   logic                             rd_en;
   logic                             wr_en;
   logic [bfsa_pkg::IDX_W-1:0]       wr_addr;
   logic [bfsa_pkg::ENTRY_W-1:0]     wr_data;
   logic [bfsa_pkg::ENTRY_W-1:0]     rd_data;
   logic [bfsa_pkg::DATA_W:0]        round_sum;
   logic [bfsa_pkg::DATA_W:0]        round_req;
   logic [bfsa_pkg::DATA_W:0]        add_sum;
   logic [bfsa_pkg::DATA_W-1:0]      sub_total;
   logic [bfsa_pkg::IDX_W-1:0]       free_idx;
   logic                             have_free;
   bfsa_pkg::scan_ctl_type           scan_ctl;
   bfsa_pkg::scan_res_type           scan_res;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign round_sum = {1'b0, req_chan.byte_count}
                      + (bfsa_pkg::DATA_W + 1)'(bfsa_pkg::GRANULE - 1);
   assign round_req = {round_sum[bfsa_pkg::DATA_W:bfsa_pkg::GRANULE_LOG2],
                       bfsa_pkg::GRANULE_LOG2'(0)};
   assign add_sum   = {1'b0, free_ff} + {1'b0, size_ff};
   assign sub_total = (free_ff >= size_ff) ? (free_ff - size_ff) : '0;

   always_comb begin
      free_idx  = '0;
      have_free = 1'b0;
      for (int i = bfsa_pkg::SEGMENTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx  = bfsa_pkg::IDX_W'(i);
            have_free = 1'b1;
         end
      end
   end

   bfsa_ram #(
      .WIDTH (bfsa_pkg::ENTRY_W),
      .DEPTH (bfsa_pkg::SEGMENTS)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[bfsa_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign scan_ctl.clear       = accept;
   assign scan_ctl.check       = chk_vld_ff;
   assign scan_ctl.entry_valid = valid_ff[chk_idx_ff];
   assign scan_ctl.idx         = chk_idx_ff;

   bfsa_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .req_size (size_ff),
      .rd_data  (rd_data),
      .res      (scan_res)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      start_in      = start_ff;
      size_in       = size_ff;
      err_in        = err_ff;
      ptr_in        = ptr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      valid_in      = valid_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_total_in  = rsp_total_ff;
      req_chan.ready = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = free_idx;
      wr_data       = {start_ff, size_ff};

      unique case (state_ff)
         bfsa_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               kind_in  = req_chan.kind;
               start_in = req_chan.seg_start;
               ptr_in   = '0;
               if (req_chan.kind == bfsa_pkg::KIND_LOAD) begin
                  size_in  = req_chan.byte_count;
                  err_in   = (req_chan.byte_count == '0) ? bfsa_pkg::ST_ZERO
                                                          : bfsa_pkg::ST_OK;
                  state_in = bfsa_pkg::S_FINISH;
               end else begin
                  size_in = round_req[bfsa_pkg::DATA_W-1:0];
                  if (req_chan.byte_count == '0) begin
                     err_in   = bfsa_pkg::ST_ZERO;
                     state_in = bfsa_pkg::S_FINISH;
                  end else if (round_req[bfsa_pkg::DATA_W]) begin
                     err_in   = bfsa_pkg::ST_NOFIT;
                     state_in = bfsa_pkg::S_FINISH;
                  end else begin
                     err_in   = bfsa_pkg::ST_OK;
                     state_in = bfsa_pkg::S_SCAN;
                  end
               end
            end
         end
         bfsa_pkg::S_SCAN: begin
            if (ptr_ff != bfsa_pkg::PTR_W'(bfsa_pkg::SEGMENTS)) begin
               rd_en      = 1'b1;
               ptr_in     = ptr_ff + bfsa_pkg::PTR_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[bfsa_pkg::IDX_W-1:0];
            end else if (!chk_vld_ff) begin
               state_in = bfsa_pkg::S_FINISH;
            end
         end
         bfsa_pkg::S_FINISH: begin
            if (slot_free) begin
               state_in      = bfsa_pkg::S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = err_ff;
               rsp_addr_in   = '0;
               if (err_ff == bfsa_pkg::ST_OK) begin
                  if (kind_ff == bfsa_pkg::KIND_LOAD) begin
                     if (have_free) begin
                        wr_en              = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        free_in = add_sum[bfsa_pkg::DATA_W] ? '1
                                                            : add_sum[bfsa_pkg::DATA_W-1:0];
                     end else begin
                        rsp_status_in = bfsa_pkg::ST_FULL;
                     end
                  end else if (scan_res.exact) begin
                     valid_in[scan_res.idx] = 1'b0;
                     rsp_addr_in            = scan_res.base;
                     free_in                = sub_total;
                  end else if (scan_res.found) begin
                     wr_en       = 1'b1;
                     wr_addr     = scan_res.idx;
                     wr_data     = {scan_res.base + size_ff, scan_res.len - size_ff};
                     rsp_addr_in = scan_res.base;
                     free_in     = sub_total;
                  end else begin
                     rsp_status_in = bfsa_pkg::ST_NOFIT;
                  end
               end
               rsp_total_in = free_in;
            end
         end
         default: begin
            state_in = bfsa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfsa_pkg::S_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      start_ff      <= start_in;
      size_ff       <= size_in;
      err_ff        <= err_in;
      ptr_ff        <= ptr_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.block_address = rsp_addr_ff;
   assign rsp_chan.free_total    = rsp_total_ff;

`ifndef NO_ASSERTIONS
   a_check_in_scan : assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> state_ff == bfsa_pkg::S_SCAN)
      else $error("entry check outside scan");

   a_write_in_finish : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bfsa_pkg::S_FINISH && slot_free))
      else $error("segment RAM write outside finish");

   a_err_addr_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != bfsa_pkg::ST_OK) |-> rsp_addr_ff == '0)
      else $error("nonzero address on error response");

   a_finish_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfsa_pkg::S_FINISH && !slot_free) |=> state_ff == bfsa_pkg::S_FINISH)
      else $error("finished item dropped while response stalled");
`endif

endmodule

`default_nettype wire

### hw/rtl/bfsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bfsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/bfsa_scan.sv
// Best-fit tracker: looks at one table entry per cycle as read data returns
// and keeps the first exact match or the shortest segment that still fits.
// Depends on bfsa_pkg.
`default_nettype none

module bfsa_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bfsa_pkg::scan_ctl_type        ctl,
   input  wire logic [bfsa_pkg::DATA_W-1:0]   req_size,
   input  wire logic [bfsa_pkg::ENTRY_W-1:0]  rd_data,
   output      bfsa_pkg::scan_res_type        res
);

   bfsa_pkg::scan_res_type        res_ff;
   bfsa_pkg::scan_res_type        res_in;
   logic [bfsa_pkg::DATA_W-1:0]   ent_base;
   logic [bfsa_pkg::DATA_W-1:0]   ent_len;

   assign ent_base = rd_data[bfsa_pkg::ENTRY_W-1:bfsa_pkg::DATA_W];
   assign ent_len  = rd_data[bfsa_pkg::DATA_W-1:0];
   assign res      = res_ff;

   always_comb begin
      res_in = res_ff;
      if (ctl.clear) begin
         res_in.exact = 1'b0;
         res_in.found = 1'b0;
      end else if (ctl.check && ctl.entry_valid && !res_ff.exact) begin
         if (ent_len == req_size) begin
            res_in.exact = 1'b1;
            res_in.found = 1'b1;
            res_in.idx   = ctl.idx;
            res_in.base  = ent_base;
            res_in.len   = ent_len;
         end else if (ent_len > req_size && (!res_ff.found || ent_len < res_ff.len)) begin
            res_in.found = 1'b1;
            res_in.idx   = ctl.idx;
            res_in.base  = ent_base;
            res_in.len   = ent_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire
